@@ rtl/ssd_pkg.sv @@
// Shared types, constants and arithmetic helpers for the smooth sign unit.
// Pseudo-float magnitudes: 32-bit normalized mantissa plus signed exponent.
// No dependencies.
package ssd_pkg;

   localparam int EW         = 12;   // exponent width
   localparam int SQ_STAGES  = 16;   // square root stages, two root bits each
   localparam int DV_STAGES  = 17;   // reciprocal stages, two quotient bits each
   localparam int RS_STAGES  = SQ_STAGES + DV_STAGES;
   localparam int FE_STAGES  = 7;    // front end register stages
   localparam int BE_STAGES  = 7;    // back end register stages

   typedef struct packed {
      logic [31:0]          m;
      logic signed [EW-1:0] e;
   } xnum_type;

   localparam xnum_type X_ZERO  = '{m: 32'h0000_0000, e: EW'(0)};
   localparam xnum_type X_ONE   = '{m: 32'h8000_0000, e: EW'(-31)};
   localparam xnum_type X_THREE = '{m: 32'hC000_0000, e: EW'(-30)};

   // data carried next to the reciprocal square root
   typedef struct packed {
      logic     xneg;
      logic     dneg;
      xnum_type a;
      xnum_type t;
      xnum_type tx3;
      xnum_type td;
   } side_type;

   typedef struct packed {
      logic signed [23:0] value;
      logic signed [47:0] slope;
      logic signed [47:0] curv;
      logic signed [47:0] third;
   } res_type;

   function automatic xnum_type xmul(xnum_type a, xnum_type b);
      logic [63:0] p;
      xnum_type    r;
      p = {32'd0, a.m} * {32'd0, b.m};
      if (a.m == 32'd0 || b.m == 32'd0) begin
         r = X_ZERO;
      end else if (p[63]) begin
         r.m = p[63:32];
         r.e = a.e + b.e + EW'(32);
      end else begin
         r.m = p[62:31];
         r.e = a.e + b.e + EW'(31);
      end
      return r;
   endfunction

   // left-normalize a mantissa; zero stays exact zero
   function automatic xnum_type xnorm(logic [31:0] m, logic signed [EW-1:0] e);
      logic [4:0] pos;
      xnum_type   r;
      pos = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (m[i]) pos = 5'(i);
      end
      if (m == 32'd0) begin
         r = X_ZERO;
      end else begin
         r.m = m << (5'd31 - pos);
         r.e = e - EW'(5'd31 - pos);
      end
      return r;
   endfunction

endpackage

@@ rtl/ssd_front.sv @@
// Front end: normalizes a and x, forms a*x, (a*x)^2, 3a^3, 1+u, 4u-1 and products.
// Depends on ssd_pkg.
module ssd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              vld_in,
   input  logic signed [23:0] x_in,
   input  logic [15:0]       sharpness,
   output logic              vld_out,
   output ssd_pkg::xnum_type w_out,
   output ssd_pkg::side_type side_out
);
   import ssd_pkg::*;

   logic [FE_STAGES-1:0] v_ff;
   logic [23:0]          x0_ff;
   xnum_type a1_ff, x1_ff;
   logic     n1_ff;
   xnum_type t2_ff, sq2_ff, a2_ff, x2_ff;
   logic     n2_ff;
   xnum_type u3_ff, c3_ff, t3_ff, a3_ff, x3_ff;
   logic     n3_ff;
   xnum_type w4_ff, k4_ff, t4_ff, a4_ff, x4_ff;
   logic [31:0]          dm4_ff;
   logic signed [EW-1:0] de4_ff;
   logic     dn4_ff, n4_ff;
   xnum_type w5_ff, k5_ff, d5_ff, tx5_ff, t5_ff, a5_ff;
   logic     dn5_ff, n5_ff;
   xnum_type w6_ff;
   side_type side6_ff;

   logic        xneg_in;
   logic [23:0] xmag_in;
   xnum_type    w_in, u4_in, big_in, small_in;
   logic signed [EW-1:0] d_in, sd_in;
   logic [32:0] sum_in;
   logic [31:0] sh_in, ssh_in;
   logic [31:0] dm_in;
   logic signed [EW-1:0] de_in;
   logic        dn_in;
   xnum_type    sbig_in, ssmall_in;

   assign xneg_in = x0_ff[23];
   assign xmag_in = xneg_in ? (24'd0 - x0_ff) : x0_ff;

   // 1 + u
   always_comb begin
      if (u3_ff.e < EW'(-31)) begin
         big_in   = X_ONE;
         small_in = u3_ff;
         d_in     = EW'(-31) - u3_ff.e;
      end else begin
         big_in   = u3_ff;
         small_in = X_ONE;
         d_in     = u3_ff.e + EW'(31);
      end
      sh_in  = (d_in >= EW'(32)) ? 32'd0 : (small_in.m >> d_in[4:0]);
      sum_in = {1'b0, big_in.m} + {1'b0, sh_in};
      if (u3_ff.m == 32'd0) begin
         w_in = X_ONE;
      end else if (sum_in[32]) begin
         w_in.m = sum_in[32:1];
         w_in.e = big_in.e + EW'(1);
      end else begin
         w_in.m = sum_in[31:0];
         w_in.e = big_in.e;
      end
   end

   // |4u - 1| before normalization, sign apart
   always_comb begin
      u4_in = (u3_ff.m == 32'd0) ? X_ZERO : xnum_type'{m: u3_ff.m, e: u3_ff.e + EW'(2)};
      if (u4_in.m == 32'd0) begin
         sbig_in   = X_ONE;
         ssmall_in = X_ZERO;
         sd_in     = EW'(32);
         dn_in     = 1'b1;
      end else if (u4_in.e >= EW'(-31)) begin
         sbig_in   = u4_in;
         ssmall_in = X_ONE;
         sd_in     = u4_in.e + EW'(31);
         dn_in     = 1'b0;
      end else begin
         sbig_in   = X_ONE;
         ssmall_in = u4_in;
         sd_in     = EW'(-31) - u4_in.e;
         dn_in     = 1'b1;
      end
      ssh_in = (sd_in >= EW'(32)) ? 32'd0 : (ssmall_in.m >> sd_in[4:0]);
      dm_in  = sbig_in.m - ssh_in;
      de_in  = sbig_in.e;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[FE_STAGES-2:0], vld_in};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x0_ff    <= x_in;
         a1_ff    <= xnorm({16'd0, sharpness}, EW'(-10));
         x1_ff    <= xnorm({8'd0, xmag_in}, EW'(-16));
         n1_ff    <= xneg_in;
         t2_ff    <= xmul(a1_ff, x1_ff);
         sq2_ff   <= xmul(a1_ff, a1_ff);
         a2_ff    <= a1_ff;
         x2_ff    <= x1_ff;
         n2_ff    <= n1_ff;
         u3_ff    <= xmul(t2_ff, t2_ff);
         c3_ff    <= xmul(sq2_ff, a2_ff);
         t3_ff    <= t2_ff;
         a3_ff    <= a2_ff;
         x3_ff    <= x2_ff;
         n3_ff    <= n2_ff;
         w4_ff    <= w_in;
         k4_ff    <= xmul(X_THREE, c3_ff);
         dm4_ff   <= dm_in;
         de4_ff   <= de_in;
         dn4_ff   <= dn_in;
         t4_ff    <= t3_ff;
         a4_ff    <= a3_ff;
         x4_ff    <= x3_ff;
         n4_ff    <= n3_ff;
         w5_ff    <= w4_ff;
         k5_ff    <= k4_ff;
         d5_ff    <= xnorm(dm4_ff, de4_ff);
         tx5_ff   <= xmul(k4_ff, x4_ff);
         dn5_ff   <= dn4_ff;
         t5_ff    <= t4_ff;
         a5_ff    <= a4_ff;
         n5_ff    <= n4_ff;
         w6_ff    <= w5_ff;
         side6_ff <= '{xneg: n5_ff, dneg: dn5_ff, a: a5_ff, t: t5_ff,
                       tx3: tx5_ff, td: xmul(k5_ff, d5_ff)};
      end
   end

   assign vld_out  = v_ff[FE_STAGES-1];
   assign w_out    = w6_ff;
   assign side_out = side6_ff;

endmodule

@@ rtl/ssd_rsqrt.sv @@
// Reciprocal square root pipeline: floor isqrt, then floor(2^63 / root).
// Depends on ssd_pkg.
module ssd_rsqrt (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    vld_in,
   input  ssd_pkg::xnum_type       w_in,
   input  ssd_pkg::side_type       side_in,
   output logic                    vld_out,
   output logic [32:0]             q_out,
   output logic signed [ssd_pkg::EW-1:0] eo_out,
   output ssd_pkg::side_type       side_out
);
   import ssd_pkg::*;

   typedef struct packed {
      logic [35:0] rem;
      logic [31:0] root;
      logic [63:0] mm;
   } sqrt_type;

   typedef struct packed {
      logic [32:0] rem;
      logic [31:0] s;
      logic [33:0] q;
   } div_type;

   function automatic sqrt_type sq_step(sqrt_type d);
      logic [35:0] rem;
      logic [35:0] trial;
      sqrt_type    r;
      rem   = {d.rem[33:0], d.mm[63:62]};
      trial = {2'b00, d.root, 2'b01};
      if (rem >= trial) begin
         r.rem  = rem - trial;
         r.root = {d.root[30:0], 1'b1};
      end else begin
         r.rem  = rem;
         r.root = {d.root[30:0], 1'b0};
      end
      r.mm = {d.mm[61:0], 2'b00};
      return r;
   endfunction

   function automatic div_type dv_step(div_type d);
      logic [32:0] rem;
      div_type     r;
      rem = {d.rem[31:0], 1'b0};
      r.s = d.s;
      if (rem >= {1'b0, d.s}) begin
         r.rem = rem - {1'b0, d.s};
         r.q   = {d.q[32:0], 1'b1};
      end else begin
         r.rem = rem;
         r.q   = {d.q[32:0], 1'b0};
      end
      return r;
   endfunction

   logic                 odd_in;
   logic signed [EW-1:0] eadj_in, eo_in;
   sqrt_type             sq_init;
   div_type              dv_init;
   sqrt_type sq_d  [SQ_STAGES];
   sqrt_type sq_ff [SQ_STAGES];
   div_type  dv_d  [DV_STAGES];
   div_type  dv_ff [DV_STAGES];
   logic [RS_STAGES-1:0] v_ff;
   side_type             side_ff [RS_STAGES];
   logic signed [EW-1:0] eo_ff   [RS_STAGES];

   // make the exponent even, mantissa to 62 or 63 bits
   assign odd_in  = w_in.e[0];
   assign eadj_in = odd_in ? (w_in.e - EW'(31)) : (w_in.e - EW'(30));
   assign eo_in   = EW'(-63) - (eadj_in >>> 1);
   assign sq_init = '{rem: 36'd0, root: 32'd0,
                      mm: odd_in ? {1'b0, w_in.m, 31'd0} : {2'b00, w_in.m, 30'd0}};
   assign dv_init = '{rem: 33'h0_2000_0000, s: sq_ff[SQ_STAGES-1].root, q: 34'd0};

   for (genvar g = 0; g < SQ_STAGES; g++) begin : g_sq
      if (g == 0) begin : g_first
         assign sq_d[g] = sq_step(sq_step(sq_init));
      end else begin : g_next
         assign sq_d[g] = sq_step(sq_step(sq_ff[g-1]));
      end
   end

   for (genvar g = 0; g < DV_STAGES; g++) begin : g_dv
      if (g == 0) begin : g_first
         assign dv_d[g] = dv_step(dv_step(dv_init));
      end else begin : g_next
         assign dv_d[g] = dv_step(dv_step(dv_ff[g-1]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[RS_STAGES-2:0], vld_in};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff      <= sq_d;
         dv_ff      <= dv_d;
         side_ff[0] <= side_in;
         eo_ff[0]   <= eo_in;
         for (int k = 1; k < RS_STAGES; k++) begin
            side_ff[k] <= side_ff[k-1];
            eo_ff[k]   <= eo_ff[k-1];
         end
      end
   end

   assign vld_out  = v_ff[RS_STAGES-1];
   assign q_out    = dv_ff[DV_STAGES-1].q[32:0];
   assign eo_out   = eo_ff[RS_STAGES-1];
   assign side_out = side_ff[RS_STAGES-1];

endmodule

@@ rtl/ssd_back.sv @@
// Back end: powers of 1/s, final products, fixed-point conversion with caps.
// Depends on ssd_pkg.
module ssd_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    vld_in,
   input  logic [32:0]             q_in,
   input  logic signed [ssd_pkg::EW-1:0] eo_in,
   input  ssd_pkg::side_type       side_in,
   output logic                    vld_out,
   output ssd_pkg::res_type        res_out
);
   import ssd_pkg::*;

   function automatic logic [22:0] fix_val(xnum_type v);
      logic signed [EW-1:0] sh;
      logic signed [EW-1:0] n;
      logic [22:0]          r;
      sh = v.e + EW'(22);
      n  = -sh;
      if (v.m == 32'd0) r = 23'd0;
      else if (sh >= EW'(-9)) r = 23'h40_0000;
      else if (n >= EW'(32)) r = 23'd0;
      else r = 23'(v.m >> n[4:0]);
      return r;
   endfunction

   function automatic logic [46:0] fix_der(xnum_type v);
      logic signed [EW-1:0] sh;
      logic signed [EW-1:0] n;
      logic [46:0]          r;
      sh = v.e + EW'(16);
      n  = -sh;
      if (v.m == 32'd0) r = 47'd0;
      else if (sh >= EW'(16)) r = 47'h7FFF_FFFF_FFFF;
      else if (sh >= EW'(0)) r = {15'd0, v.m} << sh[3:0];
      else if (n >= EW'(32)) r = 47'd0;
      else r = 47'(v.m >> n[4:0]);
      return r;
   endfunction

   function automatic logic [47:0] sgn48(logic [46:0] mag, logic neg);
      return neg ? (48'd0 - {1'b0, mag}) : {1'b0, mag};
   endfunction

   logic [BE_STAGES-1:0] v_ff;
   xnum_type r1_ff, r2_ff, rr2_ff, r3_ff, rr3_ff, r5_ff, rr4_ff, r7_ff;
   xnum_type v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   xnum_type sl4_ff, sl5_ff, sl6_ff, cv5_ff, cv6_ff, th6_ff;
   side_type s1_ff, s2_ff, s3_ff, s4_ff, s5_ff, s6_ff;
   res_type  res_ff;
   xnum_type r_in;
   logic [23:0] vm_in;

   // 1/s mantissa lies in [2^31.5, 2^32.5)
   assign r_in  = q_in[32] ? xnum_type'{m: q_in[32:1], e: eo_in + EW'(1)}
                           : xnum_type'{m: q_in[31:0], e: eo_in};
   assign vm_in = {1'b0, fix_val(v6_ff)};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[BE_STAGES-2:0], vld_in};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r1_ff  <= r_in;
         s1_ff  <= side_in;
         rr2_ff <= xmul(r1_ff, r1_ff);
         r2_ff  <= r1_ff;
         v2_ff  <= xmul(s1_ff.t, r1_ff);
         s2_ff  <= s1_ff;
         r3_ff  <= xmul(rr2_ff, r2_ff);
         rr3_ff <= rr2_ff;
         v3_ff  <= v2_ff;
         s3_ff  <= s2_ff;
         r5_ff  <= xmul(r3_ff, rr3_ff);
         rr4_ff <= rr3_ff;
         sl4_ff <= xmul(s3_ff.a, r3_ff);
         v4_ff  <= v3_ff;
         s4_ff  <= s3_ff;
         r7_ff  <= xmul(r5_ff, rr4_ff);
         cv5_ff <= xmul(s4_ff.tx3, r5_ff);
         sl5_ff <= sl4_ff;
         v5_ff  <= v4_ff;
         s5_ff  <= s4_ff;
         th6_ff <= xmul(s5_ff.td, r7_ff);
         cv6_ff <= cv5_ff;
         sl6_ff <= sl5_ff;
         v6_ff  <= v5_ff;
         s6_ff  <= s5_ff;
         res_ff.value <= s6_ff.xneg ? (24'd0 - vm_in) : vm_in;
         res_ff.slope <= sgn48(fix_der(sl6_ff), 1'b0);
         res_ff.curv  <= sgn48(fix_der(cv6_ff), !s6_ff.xneg);
         res_ff.third <= sgn48(fix_der(th6_ff), s6_ff.dneg);
      end
   end

   assign vld_out = v_ff[BE_STAGES-1];
   assign res_out = res_ff;

endmodule

@@ rtl/smooth_sign_with_derivatives.sv @@
// Top level of the smooth sign unit: a*x/s and three derivatives, s = sqrt(a^2 x^2 + 1).
// Depends on ssd_pkg, ssd_front, ssd_rsqrt, ssd_back.
//
// Usage:
//  - req_ channel: one signed Q8.16 sample per transfer (req_valid high, req_stall low).
//  - rsp_ channel: one result per sample, in order: value (Q1.22), slope, curvature
//    and third derivative (Q31.16, saturating). A transfer completes when
//    rsp_valid is high and rsp_stall is low.
//  - csr_ channel: writes the sharpness a (unsigned Q6.10); csr_ready is always
//    high. Write only while no sample is in flight.
//  - Throughput: one sample per clock while req_stall is low. The result passes
//    7 front-end stages, 16 square root stages and 17 reciprocal stages at two
//    bits each, 7 back-end stages and the output register; the transfer edge
//    itself loads the first stage.
//  - Stall: the output register holds while rsp_stall is high; a one-entry skid
//    buffer catches the item leaving the pipeline in that cycle. Once the skid
//    entry is full the whole pipeline freezes and req_stall goes high, so
//    nothing is lost or repeated. req_stall is a register output.
//  - Reset (synchronous, active high) empties the pipeline, the output
//    register and the skid entry and sets sharpness to 0.
module smooth_sign_with_derivatives (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [23:0] req_x_in,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [23:0] rsp_value_out,
   output logic signed [47:0] rsp_slope_out,
   output logic signed [47:0] rsp_curvature_out,
   output logic signed [47:0] rsp_third_out,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [15:0]        csr_sharpness
);
   import ssd_pkg::*;

   logic        adv;              // pipeline advance
   logic        take;             // output transfer this cycle
   logic [15:0] sharp_ff;
   logic        out_vld_ff;
   logic        skid_vld_ff;
   res_type     out_ff;
   res_type     skid_ff;

   logic                 fe_vld;
   xnum_type             fe_w;
   side_type             fe_side;
   logic                 rs_vld;
   logic [32:0]          rs_q;
   logic signed [EW-1:0] rs_eo;
   side_type             rs_side;
   logic                 pv;      // item leaving the back end
   res_type              pd;

   assign adv       = !skid_vld_ff;
   assign req_stall = skid_vld_ff;
   assign take      = out_vld_ff && !rsp_stall;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sharp_ff <= 16'd0;
      end else if (csr_valid && csr_ready) begin
         sharp_ff <= csr_sharpness;
      end
   end

   ssd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .vld_in    (req_valid),
      .x_in      (req_x_in),
      .sharpness (sharp_ff),
      .vld_out   (fe_vld),
      .w_out     (fe_w),
      .side_out  (fe_side)
   );

   ssd_rsqrt u_rsqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .vld_in   (fe_vld),
      .w_in     (fe_w),
      .side_in  (fe_side),
      .vld_out  (rs_vld),
      .q_out    (rs_q),
      .eo_out   (rs_eo),
      .side_out (rs_side)
   );

   ssd_back u_back (
      .clock   (clock),
      .reset   (reset),
      .en      (adv),
      .vld_in  (rs_vld),
      .q_in    (rs_q),
      .eo_in   (rs_eo),
      .side_in (rs_side),
      .vld_out (pv),
      .res_out (pd)
   );

   // output register plus skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (take) begin
            skid_vld_ff <= 1'b0;
         end
      end else if (pv) begin
         if (out_vld_ff && !take) begin
            skid_vld_ff <= 1'b1;
         end else begin
            out_vld_ff <= 1'b1;
         end
      end else if (take) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_vld_ff) begin
         if (take) begin
            out_ff <= skid_ff;
         end
      end else if (pv) begin
         if (out_vld_ff && !take) begin
            skid_ff <= pd;
         end else begin
            out_ff <= pd;
         end
      end
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_value_out     = out_ff.value;
   assign rsp_slope_out     = out_ff.slope;
   assign rsp_curvature_out = out_ff.curv;
   assign rsp_third_out     = out_ff.third;

`ifndef SYNTH
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid entry full while output register empty");

   a_skid_catch: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && rsp_stall && pv && !skid_vld_ff) |=> skid_vld_ff)
      else $error("item leaving pipeline under stall not caught");

   a_value_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_value_out[23] == rsp_value_out[22] ||
                     rsp_value_out == 24'h40_0000))
      else $error("value outside saturation range");

   a_slope_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_slope_out[47])
      else $error("negative slope");
`endif

endmodule

@@ bench/smooth_sign_with_derivatives_test.sv @@
// Self-checking bench for smooth_sign_with_derivatives: value, slope, curvature and third
// derivative of a*x/sqrt(a^2 x^2 + 1) are predicted in pseudo-float and compared per transfer.
// Depends on ssd_pkg and the smooth_sign_with_derivatives RTL.
`timescale 1ns / 100ps

module smooth_sign_with_derivatives_test;
   import ssd_pkg::*;

   // magnitude as mantissa times 2^e, mantissa normalized to [2^31, 2^32) or zero
   typedef struct {
      longint unsigned m;
      int              e;
   } pfloat_type;

   // Predicts each result from the sharpness and the sample, holds the
   // outstanding results in order and checks arriving ones against them.
   class smooth_sign_board;
      logic [15:0] sharpness;
      res_type     pending[$];
      int          errors;

      function new();
         sharpness = 16'd0;
         errors    = 0;
      endfunction

      function pfloat_type pf_make(longint unsigned m, int e);
         pfloat_type r;
         r.m = 0;
         r.e = 0;
         if (m == 0) return r;
         while (m >= 64'h1_0000_0000) begin
            m = m >> 1;
            e++;
         end
         while (m < 64'h8000_0000) begin
            m = m << 1;
            e--;
         end
         r.m = m;
         r.e = e;
         return r;
      endfunction

      function pfloat_type pf_mul(pfloat_type a, pfloat_type b);
         if (a.m == 0 || b.m == 0) return pf_make(0, 0);
         return pf_make(a.m * b.m, a.e + b.e);
      endfunction

      function longint unsigned pf_align(pfloat_type big, pfloat_type sml);
         int d;
         d = big.e - sml.e;
         return (d >= 64) ? 64'd0 : (sml.m >> d);
      endfunction

      function pfloat_type pf_add(pfloat_type a, pfloat_type b);
         pfloat_type t;
         if (a.m == 0) return b;
         if (b.m == 0) return a;
         if (a.e < b.e) begin
            t = a;
            a = b;
            b = t;
         end
         return pf_make(a.m + pf_align(a, b), a.e);
      endfunction

      // |a - b|; neg set when a < b
      function pfloat_type pf_diff(pfloat_type a, pfloat_type b, output bit neg);
         pfloat_type t;
         bit         a_big;
         neg = 1'b0;
         if (b.m == 0) return a;
         if (a.m == 0) begin
            neg = 1'b1;
            return b;
         end
         a_big = (a.e > b.e) || (a.e == b.e && a.m >= b.m);
         if (!a_big) begin
            t   = a;
            a   = b;
            b   = t;
            neg = 1'b1;
         end
         return pf_make(a.m - pf_align(a, b), a.e);
      endfunction

      function longint unsigned int_sqrt(longint unsigned n);
         longint unsigned root, bitv;
         root = 0;
         bitv = 64'd1 << 62;
         while (bitv > n) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (n >= root + bitv) begin
               n    = n - (root + bitv);
               root = (root >> 1) + bitv;
            end else begin
               root = root >> 1;
            end
            bitv = bitv >> 2;
         end
         return root;
      endfunction

      // 1/sqrt(w), w >= 1
      function pfloat_type pf_rsqrt(pfloat_type w);
         longint unsigned mm, s;
         int              e;
         mm = w.m;
         e  = w.e;
         if (e & 1) begin
            mm = mm << 1;
            e--;
         end
         mm = mm << 30;
         e  = e - 30;
         s  = int_sqrt(mm);
         if (s == 0) s = 1;
         return pf_make((64'd1 << 63) / s, -63 - e / 2);
      endfunction

      function longint unsigned to_grid(pfloat_type v, int frac, longint unsigned cap);
         int              sh;
         longint unsigned r;
         sh = v.e + frac;
         if (v.m == 0) return 0;
         if (sh >= 0) begin
            if (sh >= 32) return cap;
            r = v.m << sh;
         end else begin
            if (-sh >= 64) return 0;
            r = v.m >> (-sh);
         end
         return (r > cap) ? cap : r;
      endfunction

      function res_type predict(logic [23:0] x);
         res_type           r;
         bit                xneg, dneg;
         longint unsigned   xmag, vcap, dcap, mag;
         pfloat_type a, xv, one, t, u, rs, r2, r3, r5, r7, a3, a3x3, val, slope, curv, df, thd;
         xneg = x[23];
         xmag = xneg ? ((64'd1 << 24) - {40'd0, x}) : {40'd0, x};
         vcap = 64'd1 << 22;
         dcap = (64'd1 << 47) - 1;
         a     = pf_make({48'd0, sharpness}, -10);
         xv    = pf_make(xmag, -16);
         one   = pf_make(1, 0);
         t     = pf_mul(a, xv);
         u     = pf_mul(t, t);
         rs    = pf_rsqrt(pf_add(one, u));
         r2    = pf_mul(rs, rs);
         r3    = pf_mul(r2, rs);
         r5    = pf_mul(r3, r2);
         r7    = pf_mul(r5, r2);
         a3    = pf_mul(pf_mul(a, a), a);
         a3x3  = pf_mul(pf_make(3, 0), a3);
         val   = pf_mul(t, rs);
         slope = pf_mul(a, r3);
         curv  = pf_mul(pf_mul(a3x3, xv), r5);
         df    = pf_diff(pf_mul(pf_make(4, 0), u), one, dneg);
         thd   = pf_mul(pf_mul(a3x3, df), r7);
         mag     = to_grid(val, 22, vcap);
         r.value = xneg ? -mag[23:0] : mag[23:0];
         mag     = to_grid(slope, 16, dcap);
         r.slope = mag[47:0];
         mag     = to_grid(curv, 16, dcap);
         r.curv  = !xneg ? -mag[47:0] : mag[47:0];
         mag     = to_grid(thd, 16, dcap);
         r.third = dneg ? -mag[47:0] : mag[47:0];
         return r;
      endfunction

      function void note_sample(logic [23:0] x);
         pending.push_back(predict(x));
      endfunction

      function void check_result(res_type got);
         res_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result value=%0d", $realtime, got.value);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.value !== want.value) begin
            $display("%0t: value expected %0d actual %0d", $realtime, want.value, got.value);
            errors++;
         end
         if (got.slope !== want.slope) begin
            $display("%0t: slope expected %0d actual %0d", $realtime, want.slope, got.slope);
            errors++;
         end
         if (got.curv !== want.curv) begin
            $display("%0t: curvature expected %0d actual %0d", $realtime, want.curv, got.curv);
            errors++;
         end
         if (got.third !== want.third) begin
            $display("%0t: third expected %0d actual %0d", $realtime, want.third, got.third);
            errors++;
         end
      endfunction
   endclass

   localparam int LATENCY_WAIT = 60;       // settling wait used by drain() once every result is back
   localparam int CYCLE_LIMIT  = 2000000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [23:0] req_x_in;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [23:0] rsp_value_out;
   logic signed [47:0] rsp_slope_out;
   logic signed [47:0] rsp_curvature_out;
   logic signed [47:0] rsp_third_out;
   logic               csr_valid;
   logic               csr_ready;
   logic [15:0]        csr_sharpness;

   smooth_sign_board board;
   int               sender_idle_pct;
   int               receiver_stall_pct;
   int               cycles;

   smooth_sign_with_derivatives dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_x_in          (req_x_in),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_value_out     (rsp_value_out),
      .rsp_slope_out     (rsp_slope_out),
      .rsp_curvature_out (rsp_curvature_out),
      .rsp_third_out     (rsp_third_out),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_sharpness     (csr_sharpness)
   );

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // watchdog: a hung handshake ends the run as a failure
   initial cycles = 0;
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("smooth_sign_with_derivatives regression: fail");
         $finish;
      end
   end

   // receiver back-pressure, redrawn every falling edge
   always @(negedge clock) begin
      if (reset) rsp_stall = 1'b0;
      else       rsp_stall = ($urandom_range(99) < receiver_stall_pct);
   end

   // result transfer happens at the rising edge with valid high and stall low
   always @(posedge clock) begin
      res_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.value = rsp_value_out;
         got.slope = rsp_slope_out;
         got.curv  = rsp_curvature_out;
         got.third = rsp_third_out;
         board.check_result(got);
      end
   end

   // one sample transfer; random idle gaps ahead of it
   task automatic send_sample(logic [23:0] x);
      while ($urandom_range(99) < sender_idle_pct) @(negedge clock);
      req_valid = 1'b1;
      req_x_in  = x;
      do @(posedge clock); while (req_stall);
      board.note_sample(x);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // wait until every outstanding result is back, then let the pipe drain
   task automatic drain();
      while (board.pending.size() != 0) @(negedge clock);
      repeat (LATENCY_WAIT) @(negedge clock);
   endtask

   task automatic write_sharpness(logic [15:0] a);
      csr_valid     = 1'b1;
      csr_sharpness = a;
      do @(posedge clock); while (!csr_ready);
      board.sharpness = a;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // four in ten full-range samples, some near the knee a*x ~ 1, some extremes
   function automatic logic [23:0] pick_sample();
      logic [23:0] x;
      case ($urandom_range(9))
         0, 1, 2, 3: x = 24'($urandom);
         4, 5, 6:    x = 24'($signed($urandom_range(4096)) - 2048);
         7:          x = 24'($signed($urandom_range(262144)) - 131072);
         default:    x = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
      endcase
      return x;
   endfunction

   initial begin
      logic [23:0] directed_x[10];
      logic [15:0] block_sharp;
      board              = new();
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_x_in           = '0;
      rsp_stall          = 1'b0;
      csr_valid          = 1'b0;
      csr_sharpness      = '0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      directed_x = '{24'h000000, 24'h000001, 24'hFFFFFF, 24'h7FFFFF, 24'h800000,
                     24'h010000, 24'hFF0000, 24'h008000, 24'h000400, 24'hFFFC00};
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: zero sharpness from reset, then unit slope and the maximum
      for (int i = 0; i < 6; i++) send_sample(directed_x[i]);
      drain();
      write_sharpness(16'd1024);
      for (int i = 0; i < 10; i++) send_sample(directed_x[i]);
      drain();
      write_sharpness(16'hFFFF);
      for (int i = 0; i < 10; i++) send_sample(directed_x[i]);
      drain();

      // random blocks, idle pattern changes every two blocks
      for (int blk = 0; blk < 6; blk++) begin
         case (blk)
            0:       block_sharp = 16'd1;
            1:       block_sharp = 16'hFFFF;
            2:       block_sharp = 16'd0;
            3:       block_sharp = 16'($urandom_range(4095));
            default: block_sharp = 16'($urandom);
         endcase
         write_sharpness(block_sharp);
         sender_idle_pct    = (blk < 2) ? 32 : (blk < 4) ? 80 : 0;
         receiver_stall_pct = (blk < 2) ? 80 : (blk < 4) ? 32 : 0;
         for (int n = 0; n < 250; n++) begin
            // hold off once so the pipe runs completely empty mid-stream
            if (blk == 0 && n == 125) begin
               while (board.pending.size() != 0) @(negedge clock);
            end
            send_sample(pick_sample());
         end
         drain();
      end

      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("smooth_sign_with_derivatives regression: pass");
      end else begin
         $display("smooth_sign_with_derivatives regression: fail");
      end
      $finish;
   end

endmodule
